>>> hdl/rtbk_pkg.sv
// Shared types and constants of the repeating timer bank.
package rtbk_pkg;

   localparam int ID_W        = 8;
   localparam int DATA_W      = 32;
   localparam int MAX_RESULTS = 8;
   localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [1:0] {
      OP_SET_INTERVAL = 2'd0,
      OP_RUN          = 2'd1,
      OP_STOP         = 2'd2,
      OP_TICK         = 2'd3
   } op_type;

   typedef enum logic {
      EV_FIRED  = 1'b0,
      EV_BAD_ID = 1'b1
   } event_type;

   // One classified command as it waits between the front and the sequencer.
   typedef struct packed {
      op_type              op;
      logic                bad_id;
      logic [ID_W-1:0]     timer_id;
      logic [DATA_W-1:0]   amount;
      logic [DATA_W-1:0]   now;
   } item_type;

   typedef struct packed {
      logic [DATA_W-1:0] period;
      logic [DATA_W-1:0] repeats_left;
      logic [DATA_W-1:0] deadline;
   } timer_entry_type;

endpackage

>>> hdl/rtbk_front.sv
// Front end: accepts commands, flags bad timer ids and queues them for the sequencer.
module rtbk_front
   import rtbk_pkg::*;
#(
   parameter int TIMER_COUNT = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_op,
   input  logic [ID_W-1:0]     req_timer_id,
   input  logic [DATA_W-1:0]   req_amount,
   input  logic [DATA_W-1:0]   req_now,
   output logic                head_valid,
   output item_type            head_item,
   input  logic                head_pop
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   item_type              queue_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  push;
   item_type              new_item;

   assign req_ready  = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign push       = req_valid && req_ready;
   assign head_valid = (count_ff != '0);
   assign head_item  = queue_ff[rd_ptr_ff];

   always_comb begin
      new_item.op       = op_type'(req_op);
      new_item.timer_id = req_timer_id;
      new_item.amount   = req_amount;
      new_item.now      = req_now;
      // A tick addresses no timer, so its id is never rejected.
      new_item.bad_id   = (op_type'(req_op) != OP_TICK) &&
                          (req_timer_id >= ID_W'(TIMER_COUNT));
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (head_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      case ({push, head_pop})
         2'b10:   count_in = count_ff + CNT_W'(1);
         2'b01:   count_in = count_ff - CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         queue_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

>>> hdl/rtbk_exec.sv
// Back end: timer table, command sequencer, tick scan and result register.
module rtbk_exec
   import rtbk_pkg::*;
#(
   parameter int TIMER_COUNT = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                head_valid,
   input  item_type            head_item,
   output logic                head_pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_event_res,
   output logic [ID_W-1:0]     rsp_which_timer,
   output logic                rsp_last
);

   localparam int IDX_W = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TIMER_COUNT - 1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_SCAN,
      S_FLUSH
   } state_type;

   // Timer table with one valid bit per entry; an entry never written reads as zero.
   timer_entry_type          timer_mem_ff [TIMER_COUNT];
   logic [TIMER_COUNT-1:0]   entry_valid_ff;
   timer_entry_type          rd_data_ff;
   logic                     rd_valid_ff;
   logic                     rd_en;
   logic [IDX_W-1:0]         rd_addr;
   logic                     mem_we;
   logic [IDX_W-1:0]         wr_addr;
   timer_entry_type          wr_data;
   timer_entry_type          entry;

   state_type                state_ff, state_in;
   item_type                 cur_ff, cur_in;
   logic [IDX_W-1:0]         proc_idx_ff, proc_idx_in;
   logic [RES_CNT_W-1:0]     res_cnt_ff, res_cnt_in;
   logic                     pend_valid_ff, pend_valid_in;
   logic [IDX_W-1:0]         pend_idx_ff, pend_idx_in;

   logic                     out_valid_ff;
   logic                     out_event_ff;
   logic [ID_W-1:0]          out_which_ff;
   logic                     out_last_ff;
   logic                     out_free;
   logic                     push;
   event_type                push_event;
   logic [ID_W-1:0]          push_which;
   logic                     push_last;

   logic                     due;
   logic                     fire;
   logic                     stall;

   assign out_free = !out_valid_ff || rsp_ready;
   assign entry    = rd_valid_ff ? rd_data_ff : '0;

   assign due  = (entry.deadline != '0) && (entry.deadline <= cur_ff.now);
   assign fire = due && (res_cnt_ff < RES_CNT_W'(MAX_RESULTS));
   // A second due timer can only be taken once the held result has left.
   assign stall = (state_ff == S_SCAN) && fire && pend_valid_ff && !out_free;

   always_comb begin
      state_in      = state_ff;
      cur_in        = cur_ff;
      proc_idx_in   = proc_idx_ff;
      res_cnt_in    = res_cnt_ff;
      pend_valid_in = pend_valid_ff;
      pend_idx_in   = pend_idx_ff;
      head_pop      = 1'b0;
      rd_en         = 1'b0;
      rd_addr       = '0;
      mem_we        = 1'b0;
      wr_addr       = proc_idx_ff;
      wr_data       = entry;
      push          = 1'b0;
      push_event    = EV_FIRED;
      push_which    = ID_W'(pend_idx_ff);
      push_last     = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (head_valid) begin
               if (head_item.op == OP_TICK) begin
                  head_pop      = 1'b1;
                  cur_in        = head_item;
                  rd_en         = 1'b1;
                  rd_addr       = '0;
                  proc_idx_in   = '0;
                  res_cnt_in    = '0;
                  pend_valid_in = 1'b0;
                  state_in      = S_SCAN;
               end else if (head_item.bad_id) begin
                  if (out_free) begin
                     head_pop   = 1'b1;
                     push       = 1'b1;
                     push_event = EV_BAD_ID;
                     push_which = head_item.timer_id;
                     push_last  = 1'b1;
                  end
               end else begin
                  head_pop    = 1'b1;
                  cur_in      = head_item;
                  rd_en       = 1'b1;
                  rd_addr     = head_item.timer_id[IDX_W-1:0];
                  proc_idx_in = head_item.timer_id[IDX_W-1:0];
                  state_in    = S_EXEC;
               end
            end
         end

         S_EXEC: begin
            mem_we = 1'b1;
            case (cur_ff.op)
               OP_SET_INTERVAL: begin
                  wr_data.period       = cur_ff.amount;
                  wr_data.repeats_left = '0;
                  wr_data.deadline     = '0;
               end
               OP_RUN: begin
                  wr_data.repeats_left = cur_ff.amount;
                  wr_data.deadline     = cur_ff.now + entry.period;
               end
               default: begin
                  wr_data.deadline = '0;
               end
            endcase
            state_in = S_IDLE;
         end

         S_SCAN: begin
            if (!stall) begin
               if (fire) begin
                  mem_we = 1'b1;
                  // The last repeat, or a run count of zero, leaves the timer idle.
                  if (entry.repeats_left <= DATA_W'(1)) begin
                     wr_data.repeats_left = '0;
                     wr_data.deadline     = '0;
                  end else begin
                     wr_data.repeats_left = entry.repeats_left - DATA_W'(1);
                     wr_data.deadline     = entry.deadline + entry.period;
                  end
                  if (pend_valid_ff) begin
                     push = 1'b1;
                  end
                  pend_valid_in = 1'b1;
                  pend_idx_in   = proc_idx_ff;
                  res_cnt_in    = res_cnt_ff + RES_CNT_W'(1);
               end
               if (proc_idx_ff == LAST_IDX) begin
                  state_in = S_FLUSH;
               end else begin
                  proc_idx_in = proc_idx_ff + IDX_W'(1);
                  rd_en       = 1'b1;
                  rd_addr     = proc_idx_ff + IDX_W'(1);
               end
            end
         end

         S_FLUSH: begin
            if (pend_valid_ff) begin
               if (out_free) begin
                  push          = 1'b1;
                  push_last     = 1'b1;
                  pend_valid_in = 1'b0;
                  state_in      = S_IDLE;
               end
            end else begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         pend_valid_ff <= 1'b0;
         res_cnt_ff    <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pend_valid_ff <= pend_valid_in;
         res_cnt_ff    <= res_cnt_in;
         if (out_free) begin
            out_valid_ff <= push;
         end
      end
      cur_ff      <= cur_in;
      proc_idx_ff <= proc_idx_in;
      pend_idx_ff <= pend_idx_in;
      if (push) begin
         out_event_ff <= push_event;
         out_which_ff <= push_which;
         out_last_ff  <= push_last;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         timer_mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff  <= timer_mem_ff[rd_addr];
         rd_valid_ff <= entry_valid_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= '0;
      end else if (mem_we) begin
         entry_valid_ff[wr_addr] <= 1'b1;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_event_res   = out_event_ff;
   assign rsp_which_timer = out_which_ff;
   assign rsp_last        = out_last_ff;

endmodule

>>> hdl/repeating_timer_bank_core.sv
// Top level of the repeating timer bank: front end, sequencer and checks.
//
//   channel   direction  handshake            beat contents
//   req_      in         req_valid/req_ready  op, timer_id, amount, now
//   rsp_      out        rsp_valid/rsp_ready  event_res, which_timer, last
//
// A tick passes through the sequencer in steps: it fetches the first entry, visits
// each timer in turn through the table's single read and write port, and releases
// the final result. Set, run and stop read the entry, then write it back, and a
// rejected id is answered from idle. A two-entry queue lets commands arrive while a
// tick is scanning. Reset clears the queue, the sequencer and the table's valid bits.
// A stalled result port holds the scan only when a second result is ready to go.
module repeating_timer_bank_core
   import rtbk_pkg::*;
#(
   parameter int TIMER_COUNT = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_op,
   input  logic [ID_W-1:0]     req_timer_id,
   input  logic [DATA_W-1:0]   req_amount,
   input  logic [DATA_W-1:0]   req_now,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_event_res,
   output logic [ID_W-1:0]     rsp_which_timer,
   output logic                rsp_last
);

   logic      head_valid;
   item_type  head_item;
   logic      head_pop;

   rtbk_front #(
      .TIMER_COUNT (TIMER_COUNT)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_op       (req_op),
      .req_timer_id (req_timer_id),
      .req_amount   (req_amount),
      .req_now      (req_now),
      .head_valid   (head_valid),
      .head_item    (head_item),
      .head_pop     (head_pop)
   );

   rtbk_exec #(
      .TIMER_COUNT (TIMER_COUNT)
   ) u_exec (
      .clock           (clock),
      .reset           (reset),
      .head_valid      (head_valid),
      .head_item       (head_item),
      .head_pop        (head_pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_event_res   (rsp_event_res),
      .rsp_which_timer (rsp_which_timer),
      .rsp_last        (rsp_last)
   );

`ifndef SYNTHESIS
   // The sequencer never pops an empty queue.
   a_pop_needs_item: assert property (@(posedge clock) disable iff (reset)
      head_pop |-> head_valid)
      else $error("queue popped while empty");

   // A rejected id is always a lone result and lies outside the bank.
   a_bad_id_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_event_res == EV_BAD_ID) |->
         (rsp_last && rsp_which_timer >= ID_W'(TIMER_COUNT)))
      else $error("error result malformed");

   // A fired result always names a timer inside the bank.
   a_fire_in_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_event_res == EV_FIRED) |-> (rsp_which_timer < ID_W'(TIMER_COUNT)))
      else $error("fired result names a missing timer");

   // No result is offered in the cycle after reset.
   a_quiet_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered straight after reset");
`endif

endmodule
